@@ sv/tbc_pkg.sv @@
package tbc_pkg;

  localparam int ProgDepth = 4096;
  localparam int DataDepth = 32768;
  localparam int LoopDepth = 128;
  localparam int CellBits  = 32;

  typedef enum logic [2:0] {
    SYM_INC   = 3'd0,
    SYM_DEC   = 3'd1,
    SYM_RIGHT = 3'd2,
    SYM_LEFT  = 3'd3,
    SYM_OUT   = 3'd4,
    SYM_IN    = 3'd5,
    SYM_OPEN  = 3'd6,
    SYM_CLOSE = 3'd7
  } sym_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_IMBAL   = 3'd2;
  localparam logic [2:0] ST_OVF     = 3'd3;
  localparam logic [2:0] ST_REFUSED = 3'd4;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic       exec;     // execute one instruction
    logic       first;    // first execute: brackets unbalanced
    logic       load;     // append code at load address
    logic [2:0] code;
    logic [2:0] status;   // final status for items the back end only echoes
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_FETCH,
    BK_DECODE,
    BK_CELL,
    BK_SKIP_RD,
    BK_SKIP_CHK,
    BK_POP_RD,
    BK_POP_WAIT,
    BK_OUT
  } bk_state_t;

  function automatic logic [3:0] encode_symbol(input logic [7:0] ch);
    logic [3:0] r;
    case (ch)
      8'h2B:   r = {1'b0, SYM_INC};
      8'h2D:   r = {1'b0, SYM_DEC};
      8'h3E:   r = {1'b0, SYM_RIGHT};
      8'h3C:   r = {1'b0, SYM_LEFT};
      8'h2E:   r = {1'b0, SYM_OUT};
      8'h2C:   r = {1'b0, SYM_IN};
      8'h5B:   r = {1'b0, SYM_OPEN};
      8'h5D:   r = {1'b0, SYM_CLOSE};
      default: r = 4'd8;
    endcase
    return r;
  endfunction

endpackage

@@ sv/tbc_front.sv @@
module tbc_front #(
  parameter int PROG_DEPTH = tbc_pkg::ProgDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          mode,
  input  logic [7:0]    char_in,
  output tbc_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);

  localparam int LW = $clog2(PROG_DEPTH + 1);

  logic [LW-1:0] program_length;
  logic [LW-1:0] open_count;
  logic [LW-1:0] close_count;
  logic          running;
  logic [2:0]    fault;
  logic [3:0]    enc;
  tbc_pkg::cmd_t c;
  logic          take;
  logic [LW-1:0] oc_n, cc_n;

  // Two-entry queue toward the back end.
  tbc_pkg::cmd_t q [2];
  logic          rd_ptr, wr_ptr;
  logic [1:0]    cnt;

  assign full      = (cnt == 2'd2);
  assign take      = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];
  assign enc       = tbc_pkg::encode_symbol(char_in);

  always_comb begin
    c        = '0;
    c.ch     = char_in;
    c.code   = enc[2:0];
    c.status = tbc_pkg::ST_OK;
    oc_n     = open_count + LW'(enc[2:0] == tbc_pkg::SYM_OPEN);
    cc_n     = close_count + LW'(enc[2:0] == tbc_pkg::SYM_CLOSE);
    if (fault != tbc_pkg::ST_OK) begin
      c.status = fault;
    end else if (!mode) begin
      if (running) begin
        c.status = tbc_pkg::ST_REFUSED;
      end else if (enc[3]) begin
        c.status = tbc_pkg::ST_OK;
      end else if (program_length >= LW'(PROG_DEPTH)) begin
        c.status = tbc_pkg::ST_REFUSED;
      end else begin
        c.load = 1'b1;
        if (cc_n > oc_n) begin
          c.status = tbc_pkg::ST_IMBAL;
        end
      end
    end else begin
      c.exec  = 1'b1;
      c.first = !running && (open_count != close_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
      open_count     <= '0;
      close_count    <= '0;
      running        <= 1'b0;
      fault          <= tbc_pkg::ST_OK;
      rd_ptr         <= 1'b0;
      wr_ptr         <= 1'b0;
      cnt            <= 2'd0;
    end else begin
      if (take) begin
        q[wr_ptr] <= c;
        wr_ptr    <= !wr_ptr;
        if (c.load) begin
          program_length <= program_length + 1'b1;
          open_count     <= oc_n;
          close_count    <= cc_n;
          if (c.status == tbc_pkg::ST_IMBAL) begin
            fault <= tbc_pkg::ST_IMBAL;
          end
        end
        if (c.exec) begin
          running <= 1'b1;
          if (c.first) begin
            fault <= tbc_pkg::ST_IMBAL;
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(take) - 2'(cmd_valid && cmd_ready);
    end
  end

endmodule

@@ sv/tbc_back.sv @@
module tbc_back #(
  parameter int PROG_DEPTH = tbc_pkg::ProgDepth,
  parameter int DATA_DEPTH = tbc_pkg::DataDepth,
  parameter int LOOP_DEPTH = tbc_pkg::LoopDepth,
  parameter int CELL_BITS  = tbc_pkg::CellBits
) (
  input  logic          clk,
  input  logic          rst,
  input  tbc_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  output logic [7:0]    out_byte,
  output logic          out_valid,
  output logic [2:0]    status,
  output logic          empty,
  input  logic          pop
);

  localparam int LW = $clog2(PROG_DEPTH + 1);
  localparam int PA = $clog2(PROG_DEPTH);
  localparam int DA = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int SA = $clog2(LOOP_DEPTH);
  localparam int TW = $clog2(LOOP_DEPTH + 1);

  logic [2:0]           prog_mem [PROG_DEPTH];
  logic [CELL_BITS-1:0] data_mem [DATA_DEPTH];
  logic [PA-1:0]        loop_mem [LOOP_DEPTH];

  tbc_pkg::bk_state_t state, state_next;

  logic [LW-1:0]        program_length;
  logic [LW-1:0]        ip, ip_next;
  logic [DA-1:0]        dp, dp_next;
  logic [TW-1:0]        top, top_next;
  logic [LW-1:0]        depth, depth_next;
  logic [DA-1:0]        clr, clr_next;
  logic                 ovf, ovf_next;
  tbc_pkg::cmd_t        cur, cur_next;

  logic [LW-1:0]        prog_rd_addr;
  logic [2:0]           prog_q;
  logic                 dwe;
  logic [DA-1:0]        d_addr;
  logic [CELL_BITS-1:0] d_wdata, cell_q;
  logic                 swe;
  logic [SA-1:0]        s_addr;
  logic [PA-1:0]        stack_q;

  logic                 res_ld;
  logic [7:0]           res_byte;
  logic                 res_v;
  logic [2:0]           res_st;
  logic                 full_o;

  // Result register: one entry, loaded when it is free or being popped.
  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
    end else if (res_ld) begin
      empty <= 1'b0;
    end else if (pop) begin
      empty <= 1'b1;
    end
    if (res_ld) begin
      out_byte  <= res_byte;
      out_valid <= res_v;
      status    <= res_st;
    end
  end
  assign full_o = !empty && !pop;

  always_ff @(posedge clk) begin
    prog_q <= prog_mem[prog_rd_addr[PA-1:0]];
    if (cmd_valid && cmd_ready && cmd.load) begin
      prog_mem[program_length[PA-1:0]] <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (dwe) begin
      data_mem[d_addr] <= d_wdata;
    end
    cell_q <= data_mem[d_addr];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      loop_mem[s_addr] <= ip[PA-1:0];
    end
    stack_q <= loop_mem[s_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tbc_pkg::BK_CLEAR;
      program_length <= '0;
      ip             <= '0;
      dp             <= '0;
      top            <= '0;
      clr            <= '0;
      ovf            <= 1'b0;
    end else begin
      state <= state_next;
      ip    <= ip_next;
      dp    <= dp_next;
      top   <= top_next;
      clr   <= clr_next;
      ovf   <= ovf_next;
      if (cmd_valid && cmd_ready && cmd.load) begin
        program_length <= program_length + 1'b1;
      end
    end
    cur   <= cur_next;
    depth <= depth_next;
  end

  always_comb begin
    state_next   = state;
    ip_next      = ip;
    dp_next      = dp;
    top_next     = top;
    clr_next     = clr;
    ovf_next     = ovf;
    cur_next     = cur;
    depth_next   = depth;
    cmd_ready    = 1'b0;
    prog_rd_addr = ip;
    dwe          = 1'b0;
    d_addr       = dp;
    d_wdata      = '0;
    swe          = 1'b0;
    s_addr       = SA'(top - 1'b1);
    res_ld       = 1'b0;
    res_byte     = 8'd0;
    res_v        = 1'b0;
    res_st       = tbc_pkg::ST_OK;
    case (state)
      tbc_pkg::BK_CLEAR: begin
        dwe    = 1'b1;
        d_addr = clr;
        clr_next = clr + 1'b1;
        if (clr == DA'(DATA_DEPTH - 1)) begin
          state_next = tbc_pkg::BK_IDLE;
        end
      end
      tbc_pkg::BK_IDLE: begin
        cmd_ready = !full_o;
        if (cmd_valid && !full_o) begin
          cur_next = cmd;
          if (cmd.exec && !cmd.first && !ovf) begin
            state_next = tbc_pkg::BK_FETCH;
          end else begin
            res_ld = 1'b1;
            res_st = ovf ? tbc_pkg::ST_OVF :
                     (cmd.exec ? tbc_pkg::ST_IMBAL : cmd.status);
          end
        end
      end
      tbc_pkg::BK_FETCH: begin
        // Program and data memories read in parallel.
        if (ip >= program_length) begin
          state_next = tbc_pkg::BK_OUT;
          cur_next.status = tbc_pkg::ST_HALT;
          cur_next.code   = tbc_pkg::SYM_RIGHT;
          cur_next.load   = 1'b1;
        end else begin
          state_next = tbc_pkg::BK_DECODE;
        end
      end
      tbc_pkg::BK_DECODE: begin
        cur_next.code   = prog_q;
        cur_next.status = tbc_pkg::ST_OK;
        cur_next.load   = 1'b0;
        state_next      = tbc_pkg::BK_OUT;
        case (prog_q)
          tbc_pkg::SYM_INC: begin
            dwe = 1'b1;
            d_wdata = cell_q + 1'b1;
          end
          tbc_pkg::SYM_DEC: begin
            dwe = 1'b1;
            d_wdata = cell_q - 1'b1;
          end
          tbc_pkg::SYM_RIGHT: begin
            dp_next = (dp == DA'(DATA_DEPTH - 1)) ? '0 : dp + 1'b1;
          end
          tbc_pkg::SYM_LEFT: begin
            dp_next = (dp == '0) ? DA'(DATA_DEPTH - 1) : dp - 1'b1;
          end
          tbc_pkg::SYM_OUT: begin
            cur_next.ch   = cell_q[7:0];
            cur_next.load = 1'b1;
          end
          tbc_pkg::SYM_IN: begin
            dwe = 1'b1;
            d_wdata = CELL_BITS'(cur.ch);
          end
          tbc_pkg::SYM_OPEN: begin
            if (cell_q == '0) begin
              depth_next = '0;
              ip_next    = ip + 1'b1;
              state_next = tbc_pkg::BK_SKIP_RD;
            end else if (top >= TW'(LOOP_DEPTH)) begin
              ovf_next        = 1'b1;
              cur_next.status = tbc_pkg::ST_OVF;
            end else begin
              swe      = 1'b1;
              s_addr   = top[SA-1:0];
              top_next = top + 1'b1;
            end
          end
          default: begin
            if (top != '0) begin
              if (cell_q != '0) begin
                state_next = tbc_pkg::BK_POP_RD;
              end else begin
                top_next = top - 1'b1;
              end
            end
          end
        endcase
      end
      tbc_pkg::BK_SKIP_RD: begin
        // Walk forward one program entry per pass through SKIP_RD and SKIP_CHK.
        if (ip >= program_length) begin
          state_next = tbc_pkg::BK_OUT;
        end else begin
          state_next = tbc_pkg::BK_SKIP_CHK;
        end
      end
      tbc_pkg::BK_SKIP_CHK: begin
        state_next = tbc_pkg::BK_SKIP_RD;
        if (prog_q == tbc_pkg::SYM_OPEN) begin
          depth_next = depth + 1'b1;
          ip_next    = ip + 1'b1;
        end else if (prog_q == tbc_pkg::SYM_CLOSE) begin
          if (depth == '0) begin
            state_next = tbc_pkg::BK_OUT;
          end else begin
            depth_next = depth - 1'b1;
            ip_next    = ip + 1'b1;
          end
        end else begin
          ip_next = ip + 1'b1;
        end
      end
      tbc_pkg::BK_POP_RD: begin
        state_next = tbc_pkg::BK_POP_WAIT;
      end
      tbc_pkg::BK_POP_WAIT: begin
        ip_next    = LW'(stack_q);
        state_next = tbc_pkg::BK_OUT;
      end
      tbc_pkg::BK_OUT: begin
        if (!full_o) begin
          res_ld     = 1'b1;
          res_st     = cur.status;
          res_v      = cur.load && (cur.status == tbc_pkg::ST_OK);
          res_byte   = res_v ? cur.ch : 8'd0;
          state_next = tbc_pkg::BK_IDLE;
          if (cur.status == tbc_pkg::ST_OK && ip < program_length) begin
            ip_next = ip + 1'b1;
          end
        end
      end
      default: state_next = tbc_pkg::BK_IDLE;
    endcase
  end

endmodule

@@ sv/tape_bytecode_cpu_core.sv @@
// Tape machine for the eight-symbol language. Push items with mode 0 to load
// program characters (others are dropped) and mode 1 to execute one
// instruction; every item yields exactly one result. A front end classifies
// items and tracks load state, feeding a two-entry queue; a back end runs the
// instruction against the program, data and loop-stack memories. An executed
// instruction holds the back end through accept, program and data read,
// decode with the cell write, and result load; a close bracket that jumps
// back adds the loop-stack read, and a zero-cell open bracket walks the
// program store one entry at a time. Loads and items that are only answered
// are settled in the accept step. A result that is not popped holds the back
// end. After reset a clearing pass writes zero to every data cell, one per
// cycle, while items queue but do not run.
module tape_bytecode_cpu_core #(
  parameter int PROG_DEPTH = tbc_pkg::ProgDepth,
  parameter int DATA_DEPTH = tbc_pkg::DataDepth,
  parameter int LOOP_DEPTH = tbc_pkg::LoopDepth,
  parameter int CELL_BITS  = tbc_pkg::CellBits
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       mode,
  input  logic [7:0] char_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic [2:0] status
);

  tbc_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  // Once the stack overflows the back end echoes overflow for every later
  // transaction; loads are refused anyway since the machine is running.
  tbc_front #(.PROG_DEPTH(PROG_DEPTH)) u_front (
    .clk, .rst, .push, .full, .mode, .char_in,
    .cmd, .cmd_valid, .cmd_ready
  );

  tbc_back #(
    .PROG_DEPTH(PROG_DEPTH), .DATA_DEPTH(DATA_DEPTH),
    .LOOP_DEPTH(LOOP_DEPTH), .CELL_BITS(CELL_BITS)
  ) u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_ready,
    .out_byte, .out_valid, .status, .empty, .pop
  );

endmodule

@@ sv/tbc_checker.sv @@
module tbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       out_valid,
  input logic [2:0] status
);

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status <= tbc_pkg::ST_REFUSED)) else $error("status out of range");

  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_valid) |-> (status == tbc_pkg::ST_OK))
    else $error("output with bad status");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status))) else $error("result dropped");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && status == tbc_pkg::ST_OVF) ##1 !empty |->
    (status == tbc_pkg::ST_OVF))
    else $error("overflow not sticky");

endmodule

bind tape_bytecode_cpu_core tbc_checker u_chk (
  .clk, .rst, .empty, .pop, .out_valid, .status
);

@@ tb/tape_bytecode_cpu_core_test.sv @@
`timescale 1ns / 1ps

// Checks the tape machine in one pass from reset. A fault is sticky until
// reset, so the run loads a single program and closes on a loop stack
// overflow.
// - Load phase: dropped characters, the operations, a random body of loops
//   that always terminate, a zero-skipped filler block, and an overflow nest.
// - Execute phase: run that program, with loads refused while running, until
//   the overflow fault or the execution cap, then probe the sticky fault.
// Every transaction is predicted here and compared in order on the result side.
module tape_bytecode_cpu_core_test;

  localparam int CycleLimit = 2000000;
  localparam int NestDepth  = tbc_pkg::LoopDepth + 1;
  localparam int FillerLen  = 40;
  localparam int ExecCap    = 3000;

  typedef struct {
    logic [7:0] obyte;
    logic       ovalid;
    logic [2:0] st;
  } answer_t;

  typedef struct {
    bit       m;
    bit [7:0] ch;
    bit       typed;   // expected answer given in the row itself
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       mode = 1'b0;
  logic [7:0] char_in = 8'd0;
  logic       pop = 1'b0;
  logic       full, empty, out_valid;
  logic [7:0] out_byte;
  logic [2:0] status;

  tape_bytecode_cpu_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .char_in(char_in), .empty(empty), .pop(pop), .out_byte(out_byte),
    .out_valid(out_valid), .status(status)
  );

  always #10 clk = ~clk;

  // Machine image mirrored by the predictor.
  tbc_pkg::sym_t                prog [tbc_pkg::ProgDepth];
  int                           prog_len;
  logic [tbc_pkg::CellBits-1:0] tape [tbc_pkg::DataDepth];
  int                           dptr, iptr;
  int                           loop_pos [tbc_pkg::LoopDepth];
  int                           loop_cnt, opens, closes;
  bit                           started;
  logic [2:0]                   fault_code;

  answer_t pending [$];
  int      errors = 0;
  int      cycles = 0;
  int      burst_left = 0;

  // Map a character to its symbol; return 0 for anything outside the set.
  function automatic bit to_symbol(input logic [7:0] c, output tbc_pkg::sym_t s);
    bit ok;
    ok = 1'b1;
    s = tbc_pkg::SYM_INC;
    case (c)
      "+": s = tbc_pkg::SYM_INC;
      "-": s = tbc_pkg::SYM_DEC;
      ">": s = tbc_pkg::SYM_RIGHT;
      "<": s = tbc_pkg::SYM_LEFT;
      ".": s = tbc_pkg::SYM_OUT;
      ",": s = tbc_pkg::SYM_IN;
      "[": s = tbc_pkg::SYM_OPEN;
      "]": s = tbc_pkg::SYM_CLOSE;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic answer_t machine_step(input bit m, input logic [7:0] c);
    answer_t a;
    tbc_pkg::sym_t s;
    logic [tbc_pkg::CellBits-1:0] cur;
    int p, nest;
    bit hit;
    a.obyte = 8'd0;
    a.ovalid = 1'b0;
    a.st = tbc_pkg::ST_OK;
    if (fault_code != tbc_pkg::ST_OK) begin
      a.st = fault_code;
      return a;
    end
    if (!m) begin
      // Load: refused while running, drop non-symbols, refuse past capacity.
      if (started) a.st = tbc_pkg::ST_REFUSED;
      else if (!to_symbol(c, s)) a.st = tbc_pkg::ST_OK;
      else if (prog_len >= tbc_pkg::ProgDepth) a.st = tbc_pkg::ST_REFUSED;
      else begin
        prog[prog_len] = s;
        prog_len++;
        if (s == tbc_pkg::SYM_OPEN) opens++;
        else if (s == tbc_pkg::SYM_CLOSE) closes++;
        if (closes > opens) begin
          fault_code = tbc_pkg::ST_IMBAL;
          a.st = tbc_pkg::ST_IMBAL;
        end
      end
      return a;
    end
    if (!started) begin
      started = 1'b1;
      if (opens != closes) begin
        fault_code = tbc_pkg::ST_IMBAL;
        a.st = tbc_pkg::ST_IMBAL;
        return a;
      end
    end
    if (iptr >= prog_len) begin
      a.st = tbc_pkg::ST_HALT;
      return a;
    end
    cur = tape[dptr];
    case (prog[iptr])
      tbc_pkg::SYM_INC:   tape[dptr] = cur + 1'b1;
      tbc_pkg::SYM_DEC:   tape[dptr] = cur - 1'b1;
      tbc_pkg::SYM_RIGHT: dptr = (dptr + 1 >= tbc_pkg::DataDepth) ? 0 : dptr + 1;
      tbc_pkg::SYM_LEFT:  dptr = (dptr == 0) ? tbc_pkg::DataDepth - 1 : dptr - 1;
      tbc_pkg::SYM_OUT: begin
        a.obyte = cur[7:0];
        a.ovalid = 1'b1;
      end
      tbc_pkg::SYM_IN:    tape[dptr] = tbc_pkg::CellBits'(c);
      tbc_pkg::SYM_OPEN: begin
        if (cur == '0) begin
          // Skip to the matching close bracket, not the first one.
          nest = 0;
          hit = 1'b0;
          for (p = iptr + 1; p < prog_len; p++) begin
            if (prog[p] == tbc_pkg::SYM_OPEN) nest++;
            else if (prog[p] == tbc_pkg::SYM_CLOSE) begin
              if (nest == 0) begin
                hit = 1'b1;
                break;
              end
              nest--;
            end
          end
          iptr = hit ? p : prog_len;
        end else begin
          if (loop_cnt >= tbc_pkg::LoopDepth) begin
            fault_code = tbc_pkg::ST_OVF;
            a.st = tbc_pkg::ST_OVF;
            return a;
          end
          loop_pos[loop_cnt] = iptr;
          loop_cnt++;
        end
      end
      default: begin
        if (loop_cnt > 0) begin
          if (cur != '0) iptr = loop_pos[loop_cnt - 1];
          else loop_cnt--;
        end
      end
    endcase
    if (iptr < prog_len) iptr++;
    return a;
  endfunction

  task automatic note_fail(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // Hold the transaction until accepted, then record its expected answer.
  task automatic send(input bit m, input logic [7:0] c, input bit typed = 1'b0,
                      input answer_t given = '{8'd0, 1'b0, tbc_pkg::ST_OK});
    answer_t a;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    push <= 1'b1;
    mode <= m;
    char_in <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    a = machine_step(m, c);
    pending.push_back(typed ? given : a);
  endtask

  // Hold off until every expected answer has come back.
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  // Append a program string, dropping in stray bytes now and then.
  task automatic load_text(input string txt);
    tbc_pkg::sym_t s;
    logic [7:0] junk;
    for (int i = 0; i < txt.len(); i++) begin
      if ($urandom_range(0, 11) == 0) begin
        junk = 8'($urandom_range(0, 255));
        if (!to_symbol(junk, s)) send(1'b0, junk);
      end
      send(1'b0, txt[i]);
    end
  endtask

  // Receiver: stall on a slowly rotating pattern and check each pop.
  always @(posedge clk) begin
    answer_t e;
    int phase;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end else if (!rst) begin
      if (pop && !empty) begin
        if (pending.size() == 0) note_fail("result with nothing expected");
        else begin
          e = pending.pop_front();
          if (out_byte !== e.obyte || out_valid !== e.ovalid || status !== e.st)
            note_fail($sformatf("exp byte %h valid %b status %0d, got %h %b %0d",
                                e.obyte, e.ovalid, e.st, out_byte, out_valid, status));
        end
      end
      phase = (cycles / 250) % 3;
      case (phase)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        default: pop <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  initial begin
    row_t rows [$];
    string body [$];
    string txt;
    string plain;
    logic [7:0] c;
    int nest, execs, k;
    bit wide;
    answer_t ok_load;

    ok_load = '{8'd0, 1'b0, tbc_pkg::ST_OK};
    prog_len = 0; dptr = 0; iptr = 0; loop_cnt = 0;
    opens = 0; closes = 0; started = 1'b0; fault_code = tbc_pkg::ST_OK;
    foreach (tape[i]) tape[i] = '0;
    plain = "+-<>.,";

    // Directed program head: pointer wrap below zero, cell wrap, output,
    // input byte, a short counted loop, and stray bytes that must be dropped.
    rows = '{'{0, "A", 1}, '{0, 8'h00, 1}, '{0, 8'hFF, 1}, '{0, 8'h80, 1},
             '{0, "<", 0}, '{0, "-", 0}, '{0, ".", 0}, '{0, "+", 0},
             '{0, "+", 0}, '{0, ".", 0}, '{0, ">", 0}, '{0, ",", 0},
             '{0, ".", 0}, '{0, "[", 0}, '{0, "-", 0}, '{0, ".", 0},
             '{0, "]", 0}, '{0, ">", 0}, '{0, ",", 0}, '{0, "[", 0},
             '{0, ">", 0}, '{0, "+", 0}, '{0, "<", 0}, '{0, "-", 0},
             '{0, "]", 0}};
    body = '{",[-]", ",[>+<-]>.<", ",[->+>+<<]>>.<<", ",[-.]",
             ",[>,[-]+<-]>.<", "+.", "-.", ">", "<", ",.", "+>-<"};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send(rows[i].m, rows[i].ch, rows[i].typed, ok_load);

    // Random body: every loop starts from a fresh input byte, so it ends.
    repeat ($urandom_range(10, 14)) load_text(body[$urandom_range(0, body.size() - 1)]);

    // Zero the cell, then a filler block that the open bracket skips whole.
    load_text(",[-][");
    nest = 0;
    for (k = 0; k < FillerLen; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          if (nest < 8) begin
            c = "[";
            nest++;
          end else c = plain[$urandom_range(0, 5)];
        end
        1: begin
          if (nest > 0) begin
            c = "]";
            nest--;
          end else c = plain[$urandom_range(0, 5)];
        end
        default: c = plain[$urandom_range(0, 5)];
      endcase
      load_text(string'(c));
    end
    repeat (nest + 1) send(1'b0, "]");

    // Overflow nest: one open bracket more than the loop stack holds.
    txt = "+";
    repeat (NestDepth) txt = {txt, "["};
    repeat (NestDepth) txt = {txt, "]"};
    load_text(txt);

    drain();

    // Run the program until the loop stack overflows or the execution cap is
    // hit. An input byte feeds a loop counter unless no loop follows it closely, so keep those small.
    execs = 0;
    while (fault_code == tbc_pkg::ST_OK && execs < ExecCap) begin
      if ($urandom_range(0, 19) == 0) send(1'b0, 8'($urandom_range(0, 255)));
      else begin
        wide = (iptr < prog_len) && (prog[iptr] == tbc_pkg::SYM_IN);
        for (k = iptr + 1; k <= iptr + 2 && k < prog_len; k++)
          if (prog[k] == tbc_pkg::SYM_OPEN) wide = 1'b0;
        c = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
        send(1'b1, c);
        execs++;
      end
    end

    // The fault must stick for every kind of transaction.
    repeat (20) send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

    drain();
    repeat (100) @(posedge clk);
    if (pending.size() != 0) note_fail("expected results left over");

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/tbc_pkg.sv
sv/tbc_front.sv
sv/tbc_back.sv
sv/tape_bytecode_cpu_core.sv
sv/tbc_checker.sv
tb/tape_bytecode_cpu_core_test.sv
